// ===== hw/rtl/sbad_pkg.sv =====
package sbad_pkg;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_CMD   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		TGT_RAM_RD     = 4'd0,
		TGT_RAM_WR     = 4'd1,
		TGT_ROM_RD     = 4'd2,
		TGT_FM_STAT    = 4'd3,
		TGT_SMP_STAT   = 4'd4,
		TGT_LATCH_RD   = 4'd5,
		TGT_FM_WR      = 4'd6,
		TGT_DAC_WR     = 4'd7,
		TGT_SMP_WR     = 4'd8,
		TGT_ROM_BANK   = 4'd9,
		TGT_SMP_BANK   = 4'd10,
		TGT_FM_ADDR    = 4'd11,
		TGT_NONE       = 4'd12,
		TGT_CMD        = 4'd13
	} target_t;

	// CPU bus map
	localparam logic [15:0] RAM_LAST      = 16'h1fff;
	localparam logic [15:0] ROM_BANK_ADDR = 16'h2000;
	localparam logic [15:0] FM_ADDR_ADDR  = 16'h2400;
	localparam logic [15:0] FM_DATA_ADDR  = 16'h2401;
	localparam logic [15:0] DAC_ADDR      = 16'h2800;
	localparam logic [15:0] SMP_ADDR      = 16'h2c00;
	localparam logic [15:0] LATCH_ADDR    = 16'h3000;
	localparam logic [15:0] SMP_BANK_ADDR = 16'h3400;
	localparam logic [15:0] WIN_FIRST     = 16'h4000;
	localparam logic [15:0] WIN_LAST      = 16'hbfff;
	localparam logic [15:0] FIXED_FIRST   = 16'hc000;

	localparam logic [18:0] BANKED_ROM_BASE = 19'h10000;
	localparam logic [18:0] FIXED_ROM_BASE  = 19'h40000;
	localparam logic [20:0] SMP_BASE_HI     = 21'h80000;
	localparam logic [20:0] SMP_BASE_LO     = 21'h40000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic [9:0]  command;
	} req_t;

	typedef struct packed {
		target_t     target;
		logic [18:0] memory_address;
		logic [7:0]  read_data;
		logic [7:0]  fm_register;
		logic        irq_request;
		logic [20:0] sample_bank_base;
		logic        dac_enabled;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  program_bank;
		logic [7:0]  fm_address_latch;
		logic [7:0]  command_latch;
		logic        irq_pending;
		logic        dac_on;
		logic [20:0] sample_bank_base;
	} board_state_t;

endpackage

// ===== hw/rtl/sbad_decode.sv =====
module sbad_decode import sbad_pkg::*; (
	input  req_t         req,
	input  board_state_t cur,
	input  logic [3:0]   sample_bank_count,
	output board_state_t nxt,
	output rsp_t         rsp
);

	logic [15:0] win_offset;
	logic [2:0]  smp_sel;

	assign win_offset = req.address - WIN_FIRST;
	assign smp_sel    = req.data[2:0];

	always_comb begin
		nxt = cur;
		rsp.target         = TGT_NONE;
		rsp.memory_address = '0;
		rsp.read_data      = '0;
		rsp.fm_register    = '0;

		unique case (kind_t'(req.kind))
			KIND_READ: begin
				priority if (req.address <= RAM_LAST) begin
					rsp.target         = TGT_RAM_RD;
					rsp.memory_address = {3'b000, req.address};
				end else if (req.address == FM_ADDR_ADDR || req.address == FM_DATA_ADDR) begin
					rsp.target = TGT_FM_STAT;
				end else if (req.address == SMP_ADDR) begin
					rsp.target = TGT_SMP_STAT;
				end else if (req.address == LATCH_ADDR) begin
					rsp.target      = TGT_LATCH_RD;
					rsp.read_data   = cur.command_latch;
					nxt.irq_pending = 1'b0;
				end else if (req.address >= WIN_FIRST && req.address <= WIN_LAST) begin
					rsp.target         = TGT_ROM_RD;
					rsp.memory_address = BANKED_ROM_BASE + {cur.program_bank, 15'h0000}
						+ {4'b0000, win_offset[14:0]};
				end else if (req.address >= FIXED_FIRST) begin
					rsp.target         = TGT_ROM_RD;
					rsp.memory_address = FIXED_ROM_BASE + {3'b000, req.address};
				end else begin
					rsp.target = TGT_NONE;
				end
			end
			KIND_WRITE: begin
				priority if (req.address <= RAM_LAST) begin
					rsp.target         = TGT_RAM_WR;
					rsp.memory_address = {3'b000, req.address};
				end else if (req.address == ROM_BANK_ADDR) begin
					rsp.target       = TGT_ROM_BANK;
					nxt.program_bank = req.data[2:0];
				end else if (req.address == FM_ADDR_ADDR) begin
					rsp.target           = TGT_FM_ADDR;
					nxt.fm_address_latch = req.data;
				end else if (req.address == FM_DATA_ADDR) begin
					rsp.target      = TGT_FM_WR;
					rsp.fm_register = cur.fm_address_latch;
				end else if (req.address == DAC_ADDR) begin
					rsp.target = TGT_DAC_WR;
				end else if (req.address == SMP_ADDR) begin
					rsp.target = TGT_SMP_WR;
				end else if (req.address == SMP_BANK_ADDR) begin
					rsp.target = TGT_SMP_BANK;
					// few banks: bit 2 enables, bit 0 picks the lower bank
					if (sample_bank_count[3:2] == 2'b00) begin
						priority if (!req.data[2]) begin
							nxt.sample_bank_base = '0;
						end else if (req.data[0]) begin
							nxt.sample_bank_base = SMP_BASE_LO;
						end else begin
							nxt.sample_bank_base = SMP_BASE_HI;
						end
					end else if (smp_sel != 3'd0) begin
						nxt.sample_bank_base = {smp_sel - 3'd1, 18'h00000};
					end
				end else begin
					rsp.target = TGT_NONE;
				end
			end
			KIND_CMD: begin
				rsp.target        = TGT_CMD;
				nxt.dac_on        = 1'b1;
				nxt.command_latch = req.command[7:0];
				if (!req.command[9]) begin
					nxt.irq_pending = 1'b1;
				end
			end
			KIND_NONE: begin
				rsp.target = TGT_NONE;
			end
			default: begin
				rsp.target = TGT_NONE;
			end
		endcase

		rsp.irq_request      = nxt.irq_pending;
		rsp.sample_bank_base = nxt.sample_bank_base;
		rsp.dac_enabled      = nxt.dac_on;
	end

endmodule

// ===== hw/rtl/sbad_state_regs.sv =====
module sbad_state_regs import sbad_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         upd_en,
	input  board_state_t nxt,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_data,
	output board_state_t cur,
	output logic [3:0]   sample_bank_count
);

	board_state_t state_q;
	logic [3:0]   bank_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (upd_en) begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= '0;
		end else if (cfg_we) begin
			bank_count_q <= cfg_data;
		end
	end

	assign cur               = state_q;
	assign sample_bank_count = bank_count_q;

endmodule

// ===== hw/rtl/sound_board_address_decoder.sv =====
// Sound board address decoder.
// Request channel (req_valid/req_ready/req) carries one CPU read, CPU write
// or host command per transaction. Response channel (rsp_valid/rsp_ready/rsp)
// returns exactly one response per request, in order: decoded target,
// physical memory address, latch read data, FM register and the board
// status (IRQ level, sample bank base, DAC enable) after the request.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the number of
// fitted sample banks; it is always ready and should be written while idle.
// A request accepted into the input register is decoded there; its response is
// loaded into the response register and shown from then on. Throughput is one
// transaction per cycle unless rsp_ready stalls, set by the single decode pass
// between the input and response registers, where the board state also updates.
// Reset clears the board state, the bank count and both valid flags.
// If rsp_ready stays low, the response register holds, the input register
// still takes one more request, and req_ready drops after that.
module sound_board_address_decoder import sbad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	logic         valid_s1;
	req_t         req_s1;
	logic         rsp_valid_q;
	rsp_t         rsp_q;
	logic         advance;
	board_state_t cur_state;
	board_state_t nxt_state;
	logic [3:0]   sample_bank_count;
	rsp_t         dec_rsp;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	sbad_decode u_decode (
		.req               (req_s1),
		.cur               (cur_state),
		.sample_bank_count (sample_bank_count),
		.nxt               (nxt_state),
		.rsp               (dec_rsp)
	);

	sbad_state_regs u_state (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd_en            (advance),
		.nxt               (nxt_state),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.cur               (cur_state),
		.sample_bank_count (sample_bank_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp_ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= dec_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sound_board_address_decoder_tb.sv =====
`timescale 1ns / 1ps

module sound_board_address_decoder_tb;
	import sbad_pkg::*;

	localparam logic [15:0] UNUSED_PORT = 16'h3c00;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 160;

	localparam logic [15:0] IO_PORTS [8] = '{ROM_BANK_ADDR, FM_ADDR_ADDR, FM_DATA_ADDR,
		DAC_ADDR, SMP_ADDR, LATCH_ADDR, SMP_BANK_ADDR, UNUSED_PORT};

	// Board model: tracks glue state and queues the responses it predicts.
	class decode_scoreboard;
		logic [3:0] bank_count = '0;
		logic [2:0] program_bank = '0;
		logic [7:0] fm_latch = '0;
		logic [7:0] host_latch = '0;
		logic irq = 1'b0;
		logic dac = 1'b0;
		logic [20:0] smp_base = '0;
		rsp_t expected_q[$];
		int errors = 0;

		function void set_bank_count(logic [3:0] v);
			bank_count = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			e.target = TGT_NONE;
			case (r.kind)
				KIND_READ: begin
					if (r.address <= RAM_LAST) begin
						e.target = TGT_RAM_RD;
						e.memory_address = 19'(r.address);
					end else if (r.address == FM_ADDR_ADDR || r.address == FM_DATA_ADDR) begin
						e.target = TGT_FM_STAT;
					end else if (r.address == SMP_ADDR) begin
						e.target = TGT_SMP_STAT;
					end else if (r.address == LATCH_ADDR) begin
						// latch read acknowledges the IRQ
						e.target = TGT_LATCH_RD;
						e.read_data = host_latch;
						irq = 1'b0;
					end else if (r.address >= WIN_FIRST && r.address <= WIN_LAST) begin
						e.target = TGT_ROM_RD;
						e.memory_address = BANKED_ROM_BASE + {1'b0, program_bank, 15'd0}
							+ 19'(r.address - WIN_FIRST);
					end else if (r.address >= FIXED_FIRST) begin
						e.target = TGT_ROM_RD;
						e.memory_address = FIXED_ROM_BASE + 19'(r.address);
					end
				end
				KIND_WRITE: begin
					if (r.address <= RAM_LAST) begin
						e.target = TGT_RAM_WR;
						e.memory_address = 19'(r.address);
					end else if (r.address == ROM_BANK_ADDR) begin
						e.target = TGT_ROM_BANK;
						program_bank = r.data[2:0];
					end else if (r.address == FM_ADDR_ADDR) begin
						e.target = TGT_FM_ADDR;
						fm_latch = r.data;
					end else if (r.address == FM_DATA_ADDR) begin
						e.target = TGT_FM_WR;
						e.fm_register = fm_latch;
					end else if (r.address == DAC_ADDR) begin
						e.target = TGT_DAC_WR;
					end else if (r.address == SMP_ADDR) begin
						e.target = TGT_SMP_WR;
					end else if (r.address == SMP_BANK_ADDR) begin
						e.target = TGT_SMP_BANK;
						if (bank_count <= 4'd3) begin
							if (!r.data[2])
								smp_base = '0;
							else if (r.data[0])
								smp_base = SMP_BASE_LO;
							else
								smp_base = SMP_BASE_HI;
						end else if (r.data[2:0] != 3'd0) begin
							// bank 0 select leaves the base alone
							smp_base = {3'(r.data[2:0] - 3'd1), 18'd0};
						end
					end
				end
				KIND_CMD: begin
					e.target = TGT_CMD;
					dac = 1'b1;
					host_latch = r.command[7:0];
					if (!r.command[9])
						irq = 1'b1;
				end
				default: ;
			endcase
			e.irq_request = irq;
			e.sample_bank_base = smp_base;
			e.dac_enabled = dac;
			expected_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected response, target %0d", got.target);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.target !== e.target) begin
				$error("target: expected %0d, got %0d", e.target, got.target);
				errors++;
			end
			if (got.memory_address !== e.memory_address) begin
				$error("memory_address: expected %h, got %h", e.memory_address,
					got.memory_address);
				errors++;
			end
			if (got.read_data !== e.read_data) begin
				$error("read_data: expected %h, got %h", e.read_data, got.read_data);
				errors++;
			end
			if (got.fm_register !== e.fm_register) begin
				$error("fm_register: expected %h, got %h", e.fm_register, got.fm_register);
				errors++;
			end
			if (got.irq_request !== e.irq_request) begin
				$error("irq_request: expected %b, got %b", e.irq_request, got.irq_request);
				errors++;
			end
			if (got.sample_bank_base !== e.sample_bank_base) begin
				$error("sample_bank_base: expected %h, got %h", e.sample_bank_base,
					got.sample_bank_base);
				errors++;
			end
			if (got.dac_enabled !== e.dac_enabled) begin
				$error("dac_enabled: expected %b, got %b", e.dac_enabled, got.dac_enabled);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_data = '0;

	decode_scoreboard board = new();
	int idle_max = 10;
	int responses_taken = 0;
	int quiet_cycles = 0;

	sound_board_address_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Handshakes are sampled at the falling edge, where all signals are settled.
	always @(negedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_request(input req_t r);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		forever begin
			@(negedge clk);
			if (req_ready === 1'b1)
				break;
		end
		@(posedge clk);
		board.note_request(r);
	endtask

	task automatic send_item(input kind_t k, input logic [15:0] a, input logic [7:0] d,
			input logic [9:0] c);
		req_t r;
		r.kind = k;
		r.address = a;
		r.data = d;
		r.command = c;
		send_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (board.pending() == 0)
				break;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bank_count(input logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready === 1'b1)
				break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		board.set_bank_count(v);
	endtask

	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.kind = KIND_READ;
		else if (pick < 80)
			r.kind = KIND_WRITE;
		else if (pick < 97)
			r.kind = KIND_CMD;
		else
			r.kind = KIND_NONE;
		r.data = 8'($urandom);
		r.command = 10'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 4)
			r.address = IO_PORTS[$urandom_range(0, 7)];
		else if (pick == 4)
			r.address = 16'($urandom_range(0, 16'h1fff));
		else if (pick == 5)
			r.address = 16'($urandom_range(16'h4000, 16'hbfff));
		else if (pick == 6)
			r.address = 16'($urandom_range(16'hc000, 16'hffff));
		else
			r.address = 16'($urandom);
		return r;
	endfunction

	task automatic directed_items();
		send_item(KIND_READ, 16'h0000, 8'h00, 10'h000);
		send_item(KIND_READ, RAM_LAST, 8'hff, 10'h3ff);
		send_item(KIND_READ, FM_ADDR_ADDR, 8'h00, 10'h000);
		send_item(KIND_READ, FM_DATA_ADDR, 8'h00, 10'h000);
		send_item(KIND_READ, SMP_ADDR, 8'h00, 10'h000);
		send_item(KIND_READ, WIN_FIRST, 8'h00, 10'h000);
		send_item(KIND_READ, FIXED_FIRST, 8'h00, 10'h000);
		send_item(KIND_READ, 16'hffff, 8'h00, 10'h000);
		send_item(KIND_READ, ROM_BANK_ADDR, 8'h00, 10'h000);
		send_item(KIND_WRITE, 16'h0000, 8'h00, 10'h000);
		send_item(KIND_WRITE, RAM_LAST, 8'hff, 10'h000);
		send_item(KIND_WRITE, ROM_BANK_ADDR, 8'hff, 10'h000);
		send_item(KIND_READ, WIN_LAST, 8'h00, 10'h000);
		send_item(KIND_WRITE, FM_ADDR_ADDR, 8'ha5, 10'h000);
		send_item(KIND_WRITE, FM_DATA_ADDR, 8'h5a, 10'h000);
		// DAC write before any command: still decoded, enable stays low
		send_item(KIND_WRITE, DAC_ADDR, 8'h80, 10'h000);
		send_item(KIND_CMD, 16'h0000, 8'h00, 10'h3ff);
		send_item(KIND_READ, LATCH_ADDR, 8'h00, 10'h000);
		send_item(KIND_CMD, 16'hffff, 8'hff, 10'h0ab);
		send_item(KIND_WRITE, DAC_ADDR, 8'h7f, 10'h000);
		send_item(KIND_READ, LATCH_ADDR, 8'h00, 10'h000);
		send_item(KIND_WRITE, SMP_BANK_ADDR, 8'h05, 10'h000);
		send_item(KIND_WRITE, SMP_BANK_ADDR, 8'h04, 10'h000);
		send_item(KIND_WRITE, UNUSED_PORT, 8'h12, 10'h000);
		send_item(KIND_NONE, 16'h0000, 8'hff, 10'h3ff);
	endtask

	initial begin
		int gap;
		rsp_t seen;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one long stall so the input side backs up
			gap = (responses_taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, idle_max);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			forever begin
				@(negedge clk);
				if (rsp_valid === 1'b1)
					break;
			end
			seen = rsp;
			@(posedge clk);
			responses_taken++;
			board.check_response(seen);
		end
	end

	initial begin
		logic [3:0] counts [PHASES];
		counts = '{4'd0, 4'd15, 4'd3, 4'd4, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			idle_max = (p % 3 == 1) ? 0 : 10;
			write_bank_count(counts[p]);
			if (p == 0)
				directed_items();
			// every bank select value under this rule, upper bits random
			for (int d = 0; d < 8; d++)
				send_item(KIND_WRITE, SMP_BANK_ADDR, {5'($urandom), 3'(d)}, 10'($urandom));
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_request(random_request());
			drain();
		end
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sbad_pkg.sv
hw/rtl/sbad_decode.sv
hw/rtl/sbad_state_regs.sv
hw/rtl/sound_board_address_decoder.sv
tb/sound_board_address_decoder_tb.sv
